// ===== hdl/psbw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psbw_pkg
// Shared types and constants of the packet sequence block window.
// ----------------------------------------------------------------------------
package psbw_pkg;

  // Closes one packet may cause before the window restarts at that packet.
  localparam int MAX_SKIPS = 8;
  localparam int SKIP_W    = $clog2(MAX_SKIPS + 1);

  // Serial divider: one quotient bit per cycle.
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Work queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_SEQUENCE_INCREMENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_PACKETS      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LENGTH    = 2'd2;

  localparam logic [31:0] SEQUENCE_INCREMENT_RESET = 32'd12800;
  localparam logic [15:0] BLOCK_PACKETS_RESET      = 16'd2048;
  localparam logic [15:0] EXPECTED_LENGTH_RESET    = 16'd2048;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    EV_CURRENT = 3'd0,
    EV_NEXT    = 3'd1,
    EV_LATE    = 3'd2,
    EV_LENGTH  = 3'd3,
    EV_CLOSE   = 3'd4
  } event_kind_t;

  // Classified packet handed from the front to the back.
  typedef struct packed {
    logic [63:0] seq;
    logic        len_ok;
  } work_t;

  // One result transaction.
  typedef struct packed {
    event_kind_t kind;
    logic [63:0] seq;
    logic [15:0] filled;
    logic [15:0] dropped;
    logic        resynced;
    logic        last;
  } result_t;

endpackage : psbw_pkg
`default_nettype wire

// ===== hdl/psbw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psbw_front
// Accepts packets, checks the length and divides the header counter by the
// sequence increment with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psbw_front import psbw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [63:0] header_counter,
  input  wire logic [15:0] packet_length,
  input  wire logic [31:0] sequence_increment,
  input  wire logic [15:0] expected_length,
  output logic             busy,
  output work_t            item,
  output logic             item_valid,
  input  wire logic        item_ready
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_HAND
  } front_state_t;

  front_state_t         state;
  logic [63:0]          quo;
  logic [31:0]          rem;
  logic [31:0]          divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 len_ok;

  logic [32:0] shifted;
  logic        ge;
  logic [31:0] rem_next;

  assign shifted  = {rem, quo[63]};
  assign ge       = shifted >= {1'b0, divisor};
  assign rem_next = ge ? 32'(shifted - {1'b0, divisor}) : shifted[31:0];

  assign busy       = state != F_IDLE;
  assign item_valid = state == F_HAND;
  assign item       = '{seq: quo, len_ok: len_ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            quo     <= header_counter;
            rem     <= '0;
            cnt     <= '0;
            divisor <= (sequence_increment == '0) ? 32'd1 : sequence_increment;
            len_ok  <= packet_length == expected_length;
            state   <= F_DIV;
          end
        end
        F_DIV: begin
          rem <= rem_next;
          quo <= {quo[62:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= F_HAND;
          end
        end
        F_HAND: begin
          if (item_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == F_DIV |-> divisor != '0)
    else $error("divider running with a zero divisor");
`endif

endmodule : psbw_front
`default_nettype wire

// ===== hdl/psbw_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psbw_queue
// Short queue of classified packets between the front and the back.
// ----------------------------------------------------------------------------
module psbw_queue import psbw_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire work_t push_item,
  output logic       full,
  input  wire logic  pop,
  output work_t      pop_item,
  output logic       empty
);

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full     = count == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("work queue count passed its depth");
`endif

endmodule : psbw_queue
`default_nettype wire

// ===== hdl/psbw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psbw_back
// Window engine: places packets in the current or next block, closes blocks,
// resyncs and drives the result register, one result per cycle at most.
// ----------------------------------------------------------------------------
module psbw_back import psbw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] block_packets,
  input  wire logic        in_valid,
  input  wire work_t       in_item,
  output logic             in_ready,
  output result_t          res,
  output logic             res_valid,
  input  wire logic        pop
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_LENERR,
    B_CHECK,
    B_PLACE,
    B_FINAL
  } back_state_t;

  back_state_t       state;
  logic              synced;
  logic [63:0]       ws;
  logic [15:0]       cur;
  logic [15:0]       nxt;
  logic [63:0]       seq;
  logic [SKIP_W-1:0] skips;
  logic              rs;
  logic              late;
  logic              in_cur;

  logic [15:0] b;
  logic [63:0] diff;
  logic        late_now;
  logic        in_cur_now;
  logic        beyond;
  logic        slot_free;
  logic        emit;
  logic [15:0] cur_p;
  logic [15:0] nxt_p;
  logic        need_close;
  event_kind_t place_kind;
  result_t     close_res;

  assign b          = (block_packets == '0) ? 16'd1 : block_packets;
  assign diff       = seq - ws;
  assign late_now   = seq < ws;
  assign in_cur_now = (diff[63:16] == '0) && (diff[15:0] < b);
  assign beyond     = !late_now && ((diff[63:17] != '0) || (diff[16:0] >= {b, 1'b0}));
  assign slot_free  = !res_valid || pop;
  assign in_ready   = state == B_IDLE;

  // A new result is loaded into the result register on this edge.
  assign emit = slot_free &&
                (state == B_LENERR || state == B_PLACE || state == B_FINAL ||
                 (state == B_CHECK && beyond && skips != SKIP_W'(MAX_SKIPS)));

  always_comb begin
    cur_p = cur;
    nxt_p = nxt;
    if (late) begin
      place_kind = EV_LATE;
    end else if (in_cur) begin
      place_kind = EV_CURRENT;
      if (cur != COUNT_MAX) cur_p = cur + 1'b1;
    end else begin
      place_kind = EV_NEXT;
      if (nxt != COUNT_MAX) nxt_p = nxt + 1'b1;
    end
    need_close = (cur_p >= b) || (nxt_p > (b >> 1));
  end

  assign close_res = '{kind: EV_CLOSE, seq: ws, filled: cur,
                       dropped: (cur < b) ? 16'(b - cur) : 16'd0,
                       resynced: 1'b0, last: 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
      synced    <= 1'b0;
      ws        <= '0;
      cur       <= '0;
      nxt       <= '0;
      skips     <= '0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (in_valid) begin
            seq   <= in_item.seq;
            skips <= '0;
            rs    <= 1'b0;
            if (!in_item.len_ok) begin
              state <= B_LENERR;
            end else begin
              if (!synced) begin
                synced <= 1'b1;
                ws     <= in_item.seq;
                cur    <= '0;
                nxt    <= '0;
                rs     <= 1'b1;
              end
              state <= B_CHECK;
            end
          end
        end
        B_LENERR: begin
          if (slot_free) begin
            res       <= '{kind: EV_LENGTH, seq: seq, filled: cur, dropped: 16'd0,
                           resynced: 1'b0, last: 1'b1};
            state     <= B_IDLE;
          end
        end
        B_CHECK: begin
          if (beyond) begin
            if (skips == SKIP_W'(MAX_SKIPS)) begin
              ws     <= seq;
              cur    <= '0;
              nxt    <= '0;
              rs     <= 1'b1;
              late   <= 1'b0;
              in_cur <= 1'b1;
              state  <= B_PLACE;
            end else if (slot_free) begin
              res       <= close_res;
              cur       <= nxt;
              nxt       <= '0;
              ws        <= ws + 64'(b);
              skips     <= skips + 1'b1;
            end
          end else begin
            late   <= late_now;
            in_cur <= in_cur_now;
            state  <= B_PLACE;
          end
        end
        B_PLACE: begin
          if (slot_free) begin
            res       <= '{kind: place_kind, seq: seq, filled: cur_p, dropped: 16'd0,
                           resynced: rs, last: !need_close};
            cur       <= cur_p;
            nxt       <= nxt_p;
            state     <= need_close ? B_FINAL : B_IDLE;
          end
        end
        B_FINAL: begin
          if (slot_free) begin
            res       <= '{kind: EV_CLOSE, seq: close_res.seq, filled: close_res.filled,
                           dropped: close_res.dropped, resynced: 1'b0, last: 1'b1};
            cur       <= nxt;
            nxt       <= '0;
            ws        <= ws + 64'(b);
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_skips_bounded: assert property (@(posedge clk) disable iff (rst)
    skips <= SKIP_W'(MAX_SKIPS))
    else $error("skip counter passed its limit");

  a_synced_while_working: assert property (@(posedge clk) disable iff (rst)
    (state == B_CHECK || state == B_PLACE || state == B_FINAL) |-> synced)
    else $error("window engine placing packets while unsynced");

  a_final_close_empties_next: assert property (@(posedge clk) disable iff (rst)
    (state == B_FINAL && slot_free) |=> nxt == '0)
    else $error("next block count not cleared by a close");
`endif

endmodule : psbw_back
`default_nettype wire

// ===== hdl/packet_sequence_block_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_sequence_block_window
// Sorts packets into a two-block sequence window and reports block closes.
// ----------------------------------------------------------------------------
// Usage. Packets enter as a queue write: a transaction is taken on a rising
// edge with push high and full low, carrying the raw header counter and the
// payload length. Results leave as a queue read: while empty is low the
// oldest result is on the result ports, and it is consumed on an edge with
// pop high. Each packet produces between one and MAX_SKIPS + 2 results; the
// final one of a packet carries last_result.
// Flow. The front divides the header counter by the sequence increment in a
// restoring divider, one quotient bit per cycle, so a packet holds the input
// through capture, 64 division steps and the hand-off to the work queue,
// which waits while that queue is full; full stays high meanwhile. The back
// then checks each packet and loads its results one at a time into the
// result register. A two-entry work queue between front and back lets the
// divider start the next packet while results are still draining.
// Stalls. If the receiver does not pop, the back holds its result register
// and stops, the work queue fills and full then stays high; nothing is lost.
// Reset (rst, synchronous) restores the configuration defaults, empties all
// queues and leaves the window unsynced until the next good packet.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// the block is idle; unknown indices are ignored.
// ----------------------------------------------------------------------------
module packet_sequence_block_window import psbw_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [63:0]            header_counter,
  input  wire logic [15:0]            packet_length,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [2:0]                  event_kind,
  output logic [63:0]                 sequence_number,
  output logic [15:0]                 filled_count,
  output logic [15:0]                 dropped_count,
  output logic                        resynced,
  output logic                        last_result
);

  // Configuration registers.
  logic [31:0] sequence_increment;
  logic [15:0] block_packets;
  logic [15:0] expected_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_increment <= SEQUENCE_INCREMENT_RESET;
      block_packets      <= BLOCK_PACKETS_RESET;
      expected_length    <= EXPECTED_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEQUENCE_INCREMENT: sequence_increment <= cfg_data;
        REG_BLOCK_PACKETS:      block_packets      <= cfg_data[15:0];
        REG_EXPECTED_LENGTH:    expected_length    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Front: acceptance, length check and division.
  work_t front_item;
  logic  front_valid;
  logic  q_full;

  psbw_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .header_counter     (header_counter),
    .packet_length      (packet_length),
    .sequence_increment (sequence_increment),
    .expected_length    (expected_length),
    .busy               (full),
    .item               (front_item),
    .item_valid         (front_valid),
    .item_ready         (!q_full)
  );

  // Work queue between the two halves.
  work_t q_item;
  logic  q_empty;
  logic  back_ready;

  psbw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (back_ready),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  // Back: window bookkeeping and the result register.
  result_t res;
  logic    res_valid;

  psbw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .block_packets (block_packets),
    .in_valid      (!q_empty),
    .in_item       (q_item),
    .in_ready      (back_ready),
    .res           (res),
    .res_valid     (res_valid),
    .pop           (pop)
  );

  assign empty           = !res_valid;
  assign event_kind      = res.kind;
  assign sequence_number = res.seq;
  assign filled_count    = res.filled;
  assign dropped_count   = res.dropped;
  assign resynced        = res.resynced;
  assign last_result     = res.last;

endmodule : packet_sequence_block_window
`default_nettype wire

// ===== sim/psbw_window_checker.sv =====
// ----------------------------------------------------------------------------
// psbw_window_checker
// Watches the packet and result queues of the sequence window, works out the
// results each accepted packet must cause and compares them as they leave.
// ----------------------------------------------------------------------------
module psbw_window_checker
  import psbw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  input  wire logic                   full,
  input  wire logic [63:0]            header_counter,
  input  wire logic [15:0]            packet_length,
  input  wire logic                   empty,
  input  wire logic                   pop,
  input  wire logic [2:0]             event_kind,
  input  wire logic [63:0]            sequence_number,
  input  wire logic [15:0]            filled_count,
  input  wire logic [15:0]            dropped_count,
  input  wire logic                   resynced,
  input  wire logic                   last_result,
  output int                          mismatch_count,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow configuration and window state.
  logic [31:0] incr_reg;
  logic [15:0] block_reg;
  logic [15:0] length_reg;
  logic        locked;
  logic [63:0] win_base;
  logic [15:0] cur_fill;
  logic [15:0] next_fill;

  result_t awaited_results[$];
  result_t packet_events[$];

  function automatic logic [63:0] block_span();
    return (block_reg == 16'd0) ? 64'd1 : {48'd0, block_reg};
  endfunction

  function automatic logic past_window(input logic [63:0] seq);
    return (seq >= win_base) && ((seq - win_base) >= (block_span() << 1));
  endfunction

  task automatic log_event(input event_kind_t kind, input logic [63:0] seq,
                           input logic [15:0] filled, input logic [15:0] missing,
                           input logic rs);
    result_t r;
    r.kind     = kind;
    r.seq      = seq;
    r.filled   = filled;
    r.dropped  = missing;
    r.resynced = rs;
    r.last     = 1'b0;
    packet_events.push_back(r);
  endtask

  task automatic close_current();
    logic [63:0] span;
    logic [15:0] missing;
    span    = block_span();
    missing = ({48'd0, cur_fill} < span) ? 16'(span - {48'd0, cur_fill}) : 16'd0;
    log_event(EV_CLOSE, win_base, cur_fill, missing, 1'b0);
    cur_fill  = next_fill;
    next_fill = 16'd0;
    win_base  = win_base + span;
  endtask

  task automatic restart_window(input logic [63:0] seq);
    locked    = 1'b1;
    win_base  = seq;
    cur_fill  = 16'd0;
    next_fill = 16'd0;
  endtask

  task automatic place_packet(input logic [63:0] seq, input logic rs);
    logic [63:0] span;
    event_kind_t kind;
    span = block_span();
    if (seq < win_base) begin
      kind = EV_LATE;
    end else if ((seq - win_base) < span) begin
      kind = EV_CURRENT;
      if (cur_fill != COUNT_MAX) cur_fill = cur_fill + 16'd1;
    end else begin
      kind = EV_NEXT;
      if (next_fill != COUNT_MAX) next_fill = next_fill + 16'd1;
    end
    log_event(kind, seq, cur_fill, 16'd0, rs);
    if (({48'd0, cur_fill} >= span) || ({48'd0, next_fill} > (span >> 1))) close_current();
  endtask

  task automatic predict_packet(input logic [63:0] counter, input logic [15:0] len);
    logic [63:0] divisor;
    logic [63:0] seq;
    logic        rs;
    logic        gave_up;
    int          skips;
    result_t     tail;
    packet_events.delete();
    divisor = (incr_reg == 32'd0) ? 64'd1 : {32'd0, incr_reg};
    seq     = counter / divisor;
    if (len != length_reg) begin
      // A bad length is reported and otherwise leaves the window alone.
      log_event(EV_LENGTH, seq, cur_fill, 16'd0, 1'b0);
    end else begin
      rs = 1'b0;
      if (!locked) begin
        restart_window(seq);
        rs = 1'b1;
      end
      skips   = 0;
      gave_up = 1'b0;
      while (!gave_up && past_window(seq)) begin
        close_current();
        skips++;
        if (skips >= MAX_SKIPS && past_window(seq)) begin
          restart_window(seq);
          rs      = 1'b1;
          gave_up = 1'b1;
        end
      end
      place_packet(seq, rs);
    end
    tail      = packet_events.pop_back();
    tail.last = 1'b1;
    packet_events.push_back(tail);
    foreach (packet_events[i]) awaited_results.push_back(packet_events[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40)
      $display("[%0t] mismatch on %s: got %0h, wanted %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic compare_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("result with nothing awaited", {61'd0, event_kind}, 64'd0);
    end else begin
      want = awaited_results.pop_front();
      if (event_kind !== want.kind)
        report_mismatch("event_kind", {61'd0, event_kind}, {61'd0, want.kind});
      if (sequence_number !== want.seq)
        report_mismatch("sequence_number", sequence_number, want.seq);
      if (filled_count !== want.filled)
        report_mismatch("filled_count", {48'd0, filled_count}, {48'd0, want.filled});
      if (dropped_count !== want.dropped)
        report_mismatch("dropped_count", {48'd0, dropped_count}, {48'd0, want.dropped});
      if (resynced !== want.resynced)
        report_mismatch("resynced", {63'd0, resynced}, {63'd0, want.resynced});
      if (last_result !== want.last)
        report_mismatch("last_result", {63'd0, last_result}, {63'd0, want.last});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      incr_reg   = SEQUENCE_INCREMENT_RESET;
      block_reg  = BLOCK_PACKETS_RESET;
      length_reg = EXPECTED_LENGTH_RESET;
      locked     = 1'b0;
      win_base   = 64'd0;
      cur_fill   = 16'd0;
      next_fill  = 16'd0;
      awaited_results.delete();
    end else begin
      if (pop && !empty) compare_result();
      if (push && !full) predict_packet(header_counter, packet_length);
      if (cfg_write) begin
        case (cfg_index)
          REG_SEQUENCE_INCREMENT: incr_reg   = cfg_data;
          REG_BLOCK_PACKETS:      block_reg  = cfg_data[15:0];
          REG_EXPECTED_LENGTH:    length_reg = cfg_data[15:0];
          default: ;
        endcase
      end
    end
    outstanding = awaited_results.size();
  end

endmodule : psbw_window_checker

// ===== sim/packet_sequence_block_window_tb.sv =====
// ----------------------------------------------------------------------------
// packet_sequence_block_window_tb
// Drives packets into the sequence window under a series of configurations,
// first a directed set of corner packets and then random packet streams,
// while a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module packet_sequence_block_window_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psbw_pkg::*;

  // The slowest honest pause in progress is a receiver hold-off of
  // HOLD_CYCLES plus one divide; the limit allows several times that.
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 45;
  localparam int RANDOM_PHASES = 6;

  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   cfg_write      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index      = '0;
  logic [CFG_DATA_W-1:0]  cfg_data       = '0;
  logic                   push           = 1'b0;
  logic [63:0]            header_counter = '0;
  logic [15:0]            packet_length  = '0;
  logic                   pop            = 1'b0;
  logic                   full;
  logic                   empty;
  logic [2:0]             event_kind;
  logic [63:0]            sequence_number;
  logic [15:0]            filled_count;
  logic [15:0]            dropped_count;
  logic                   resynced;
  logic                   last_result;

  int mismatch_count;
  int outstanding;
  int packets_taken = 0;
  int stall_cycles  = 0;
  int burst_left    = 0;

  // The stimulus keeps its own idea of the configuration and of where the
  // packet stream currently is, so that it can aim packets at the window.
  logic [31:0] incr_now;
  logic [15:0] block_now;
  logic [15:0] length_now;
  logic [63:0] seq_pos;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  packet_sequence_block_window dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .header_counter  (header_counter),
    .packet_length   (packet_length),
    .empty           (empty),
    .pop             (pop),
    .event_kind      (event_kind),
    .sequence_number (sequence_number),
    .filled_count    (filled_count),
    .dropped_count   (dropped_count),
    .resynced        (resynced),
    .last_result     (last_result)
  );

  psbw_window_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .header_counter  (header_counter),
    .packet_length   (packet_length),
    .empty           (empty),
    .pop             (pop),
    .event_kind      (event_kind),
    .sequence_number (sequence_number),
    .filled_count    (filled_count),
    .dropped_count   (dropped_count),
    .resynced        (resynced),
    .last_result     (last_result),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding)
  );

  function automatic logic [63:0] span_now();
    return (block_now == 16'd0) ? 64'd1 : {48'd0, block_now};
  endfunction

  // A raw counter that divides down to the given sequence number, with a
  // random remainder so that the division is exercised below the unit too.
  function automatic logic [63:0] counter_for(input logic [63:0] seq);
    logic [63:0] unit;
    unit = (incr_now == 32'd0) ? 64'd1 : {32'd0, incr_now};
    if (unit == 64'd1) return seq;
    return seq * unit + $urandom_range(0, 32'(unit - 64'd1));
  endfunction

  // Offers one packet transaction and returns on the falling edge after it
  // has been taken. The sender works in bursts; between bursts it idles for
  // a random number of cycles, now and then long enough to cover a whole
  // divide, so that gaps land on every phase of the block's work.
  task automatic offer_packet(input logic [63:0] counter, input logic [15:0] len);
    int gap;
    if (burst_left == 0) begin
      push = 1'b0;
      gap  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    push           = 1'b1;
    header_counter = counter;
    packet_length  = len;
    do @(posedge clk); while (full);
    packets_taken++;
    @(negedge clk);
  endtask

  // Lets every awaited result leave the block. Each packet causes at least
  // one result, so once nothing is awaited the block is idle; a few spare
  // cycles are allowed all the same.
  task automatic drain_results();
    push = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes all three registers on consecutive cycles; only called while idle.
  task automatic program_window(input logic [31:0] incr, input logic [15:0] blk,
                                input logic [15:0] len);
    cfg_write = 1'b1;
    cfg_index = REG_SEQUENCE_INCREMENT;
    cfg_data  = incr;
    @(negedge clk);
    cfg_index = REG_BLOCK_PACKETS;
    cfg_data  = {16'd0, blk};
    @(negedge clk);
    cfg_index = REG_EXPECTED_LENGTH;
    cfg_data  = {16'd0, len};
    @(negedge clk);
    cfg_write  = 1'b0;
    incr_now   = incr;
    block_now  = blk;
    length_now = len;
  endtask

  // One random packet. Most are a well-formed stream that walks through the
  // window with duplicates, holes and packets a little ahead; the rest are
  // late packets, jumps of a few blocks, jumps far enough to force a resync,
  // and packets with a wrong length.
  task automatic random_packet();
    int          pick;
    int          stride;
    logic [63:0] span;
    logic [15:0] bad_len;
    span = span_now();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      bad_len = 16'($urandom);
      if (bad_len == length_now) bad_len = bad_len ^ 16'h0001;
      offer_packet({$urandom, $urandom}, bad_len);
    end else if (pick < 9) begin
      offer_packet(counter_for(seq_pos), length_now ^ 16'h0001);
    end else if (pick < 13) begin
      seq_pos = seq_pos + 18 * span + $urandom_range(0, 1000);
      offer_packet(counter_for(seq_pos), length_now);
    end else if (pick < 19) begin
      seq_pos = seq_pos + span * $urandom_range(2, 5);
      offer_packet(counter_for(seq_pos), length_now);
    end else if (pick < 25) begin
      offer_packet(counter_for(seq_pos - 2 * span - $urandom_range(1, 32'(2 * span))),
                   length_now);
    end else if (pick < 35) begin
      offer_packet(counter_for(seq_pos + $urandom_range(1, 32'(span))), length_now);
    end else begin
      stride = $urandom_range(0, 9);
      if (stride == 0)
        seq_pos = seq_pos;
      else if (stride == 1)
        seq_pos = seq_pos + $urandom_range(2, (span > 64'd2) ? 32'(span) : 2);
      else
        seq_pos = seq_pos + 64'd1;
      offer_packet(counter_for(seq_pos), length_now);
    end
  endtask

  // Receiver: pops on a pattern of its own, switching between always ready,
  // half ready, mostly stalled and fully stalled stretches. Twice in the run
  // it holds off for a long time while the sender keeps offering packets,
  // so the work queue fills and the input is pushed back.
  initial begin
    int mode;
    int stretch;
    int holds_done;
    holds_done = 0;
    wait (!rst);
    forever begin
      if (holds_done < 2 && packets_taken >= 60 + 120 * holds_done) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 100);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0:       pop = 1'b1;
          1:       pop = 1'($urandom_range(0, 1));
          2:       pop = ($urandom_range(0, 3) == 0);
          default: pop = 1'b0;
        endcase
      end
    end
  end

  // Watchdog: counts cycles in which no transaction of any kind is taken.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] unit_max;
    logic [31:0] pick_incr;
    logic [15:0] pick_block;
    logic [15:0] pick_len;
    unit_max   = 64'hFFFF_FFFF;
    incr_now   = SEQUENCE_INCREMENT_RESET;
    block_now  = BLOCK_PACKETS_RESET;
    length_now = EXPECTED_LENGTH_RESET;
    rst = 1'b1;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Reset configuration. A bad length before any good packet must not
    // lock the window; the first good packet then does.
    offer_packet(64'd0, 16'd0);
    offer_packet(64'd0, 16'd2048);
    offer_packet(64'd12800 * 5 + 64'd12799, 16'd2048);
    offer_packet(64'd12800 * 2048, 16'd2048);
    // Largest counter: far beyond both blocks, so the window gives up after
    // the full run of closes and restarts there.
    offer_packet(64'hFFFF_FFFF_FFFF_FFFF, 16'd2048);
    offer_packet(64'd12800 * 3, 16'd2048);
    offer_packet(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);

    // Zero increment and zero block size both count as one. With a block of
    // one every placement closes, the window start wraps past the top of the
    // sequence space, and a far packet gives the longest burst of results.
    drain_results();
    program_window(32'd0, 16'd0, 16'd33);
    offer_packet(64'hFFFF_FFFF_FFFF_FFFE, 16'd33);
    offer_packet(64'hFFFF_FFFF_FFFF_FFFF, 16'd33);
    offer_packet(64'd0, 16'd33);
    offer_packet(64'd100, 16'd33);
    offer_packet(64'd99, 16'd32);

    // Largest increment, block size and length.
    drain_results();
    program_window(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    offer_packet(unit_max * 200 + unit_max - 64'd1, 16'hFFFF);
    offer_packet(unit_max * 50, 16'hFFFF);
    offer_packet(unit_max * (101 + 65535 + 5), 16'hFFFF);

    // Fill a block of sixteen part way, then shrink the block below the
    // count: the next packet must close the oversized block.
    drain_results();
    program_window(32'd1, 16'd16, 16'd100);
    offer_packet(64'd1000, 16'd100);
    for (int k = 1; k <= 4; k++) offer_packet(64'd1000 + k, 16'd100);
    offer_packet(64'd1020, 16'd100);
    drain_results();
    program_window(32'd1, 16'd4, 16'd100);
    offer_packet(64'd1002, 16'd100);

    // Random phases, each under a fresh configuration. The stream position
    // jumps well ahead at every phase so that the window follows it.
    seq_pos = 64'd2000;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0:       pick_incr = 32'd1;
        1:       pick_incr = $urandom_range(2, 100);
        2:       pick_incr = $urandom_range(101, 100000);
        3:       pick_incr = $urandom;
        default: pick_incr = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 9))
        0:       pick_block = 16'd1;
        1:       pick_block = 16'd2;
        8:       pick_block = 16'($urandom_range(17, 64));
        9:       pick_block = 16'hFFFF;
        default: pick_block = 16'($urandom_range(3, 16));
      endcase
      case ($urandom_range(0, 3))
        0:       pick_len = 16'd33;
        1:       pick_len = 16'hFFFF;
        default: pick_len = 16'($urandom_range(33, 65535));
      endcase
      drain_results();
      program_window(pick_incr, pick_block, pick_len);
      seq_pos = seq_pos + $urandom_range(300000, 1 << 20);
      for (int n = 0; n < PHASE_ITEMS; n++) random_packet();
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule : packet_sequence_block_window_tb
